// ===== rtl/stxdf_pkg.sv =====
// Shared types and codes for the STX/ETX packet deframer.
`default_nettype none
package stxdf_pkg;

    // Framing bytes
    localparam logic [7:0] FRAME_START = 8'h02;
    localparam logic [7:0] FRAME_END   = 8'h03;

    // Parser phase codes
    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_CMD    = 4'd1;
    localparam logic [3:0] PH_DIR    = 4'd2;
    localparam logic [3:0] PH_ERR    = 4'd3;
    localparam logic [3:0] PH_LEN_LO = 4'd4;
    localparam logic [3:0] PH_LEN_HI = 4'd5;
    localparam logic [3:0] PH_DATA   = 4'd6;
    localparam logic [3:0] PH_CHECK  = 4'd7;
    localparam logic [3:0] PH_END    = 4'd8;

    // Result event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_ACCEPT  = 2'd2;
    localparam logic [1:0] EV_REJECT  = 2'd3;

    // One result request
    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_cmd;
        logic [7:0]  frame_dir;
        logic [7:0]  frame_error;
        logic [15:0] frame_length;
    } stxdf_res_t;

endpackage
`default_nettype wire

// ===== rtl/stxdf_rx_if.sv =====
// Receive byte channel: valid/ready with one serial byte.
`default_nettype none
interface stxdf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/stxdf_res_if.sv =====
// Result channel: valid/ready with event, payload byte and held header.
`default_nettype none
interface stxdf_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_dir;
    logic [7:0]  frame_error;
    logic [15:0] frame_length;

    modport source (output valid, output event_res, output payload_byte,
                    output payload_index, output frame_cmd, output frame_dir,
                    output frame_error, output frame_length, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_index, input frame_cmd, input frame_dir,
                    input frame_error, input frame_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/stxdf_cfg_if.sv =====
// Configuration write channel: valid/ready with the enable bit.
`default_nettype none
interface stxdf_cfg_if;
    logic valid;
    logic ready;
    logic enable;

    modport source (output valid, output enable, input ready);
    modport sink   (input valid, input enable, output ready);
endinterface
`default_nettype wire

// ===== rtl/stxdf_parser.sv =====
// Frame parser: phase, checksum and header state plus per-byte result logic.
`default_nettype none
module stxdf_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  enable,
    input  wire logic [7:0]            rx_byte,
    output stxdf_pkg::stxdf_res_t      result
);
    import stxdf_pkg::*;

    logic [3:0]  phase_reg,   phase_next;
    logic [7:0]  xor_reg,     xor_next;
    logic [7:0]  check_reg,   check_next;
    logic [15:0] count_reg,   count_next;
    logic [15:0] length_reg,  length_next;
    logic [7:0]  cmd_reg,     cmd_next;
    logic [7:0]  dir_reg,     dir_next;
    logic [7:0]  error_reg,   error_next;
    logic [15:0] count_inc;
    logic [15:0] length_hi;
    logic [1:0]  event_next;
    logic [7:0]  pbyte_next;
    logic [15:0] pindex_next;

    assign count_inc = count_reg + 16'd1;
    assign length_hi = length_reg | {rx_byte, 8'h00};

    // Next state and result for the byte at the input register
    always_comb
    begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        check_next  = check_reg;
        count_next  = count_reg;
        length_next = length_reg;
        cmd_next    = cmd_reg;
        dir_next    = dir_reg;
        error_next  = error_reg;
        event_next  = EV_NONE;
        pbyte_next  = 8'h00;
        pindex_next = 16'h0000;
        if (enable)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_DIR;
                end
                PH_DIR:
                begin
                    dir_next   = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_ERR;
                end
                PH_ERR:
                begin
                    error_next = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {8'h00, rx_byte};
                    xor_next    = xor_reg ^ rx_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next = length_hi;
                    xor_next    = xor_reg ^ rx_byte;
                    if (length_hi != 16'h0000)
                    begin
                        count_next = 16'h0000;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_DATA:
                begin
                    event_next  = EV_PAYLOAD;
                    pbyte_next  = rx_byte;
                    pindex_next = count_reg;
                    xor_next    = xor_reg ^ rx_byte;
                    count_next  = count_inc;
                    if (count_inc == length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    check_next = rx_byte;
                    phase_next = PH_END;
                end
                PH_END:
                begin
                    if (rx_byte == FRAME_END && xor_reg == check_reg)
                    begin
                        event_next = EV_ACCEPT;
                    end
                    else
                    begin
                        event_next = EV_REJECT;
                    end
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    // hunting for start (unused codes hunt too)
                    if (rx_byte == FRAME_START)
                    begin
                        xor_next   = 8'h00;
                        phase_next = PH_CMD;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // Result shows header fields after this byte
    assign result = '{event_res:     event_next,
                      payload_byte:  pbyte_next,
                      payload_index: pindex_next,
                      frame_cmd:     cmd_next,
                      frame_dir:     dir_next,
                      frame_error:   error_next,
                      frame_length:  length_next};

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            xor_reg    <= 8'h00;
            check_reg  <= 8'h00;
            count_reg  <= 16'h0000;
            length_reg <= 16'h0000;
            cmd_reg    <= 8'h00;
            dir_reg    <= 8'h00;
            error_reg  <= 8'h00;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            check_reg  <= check_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            cmd_reg    <= cmd_next;
            dir_reg    <= dir_next;
            error_reg  <= error_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/stxdf_out_reg.sv =====
// Result register stage driving the result channel.
`default_nettype none
module stxdf_out_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire stxdf_pkg::stxdf_res_t data_in,
    output logic                       free,
    output logic                       valid,
    input  wire logic                  ready,
    output stxdf_pkg::stxdf_res_t      data_out
);
    import stxdf_pkg::*;

    logic       valid_reg;
    stxdf_res_t data_reg;

    // Stage can take a new result when empty or being drained
    assign free     = !valid_reg || ready;
    assign valid    = valid_reg;
    assign data_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_in;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/stx_etx_xor_packet_deframer.sv =====
// Top level of the STX/ETX packet deframer with XOR checksum.
`default_nettype none
// Parses STX(0x02) cmd dir err len_lo len_hi payload xor ETX(0x03) frames,
// one received byte per request. Every accepted byte yields exactly one
// result: 0 nothing, 1 payload byte (with its index), 2 frame accepted,
// 3 frame rejected (bad ETX or checksum); the held header fields ride along
// on every result. Each byte passes through the input register, then the parser
// and result register; a new byte is taken every cycle while the result side
// keeps up. With enable clear, bytes are consumed and yield event 0.
module stx_etx_xor_packet_deframer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    stxdf_cfg_if.sink  cfg,
    stxdf_rx_if.sink   rx,
    stxdf_res_if.source res
);
    import stxdf_pkg::*;

    logic       enable_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       step;
    logic       out_valid;
    stxdf_res_t result;
    stxdf_res_t out_data;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            enable_reg <= cfg.enable;
        end
    end

    // Input register
    assign step     = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    stxdf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .enable  (enable_reg),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    stxdf_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .data_in  (result),
        .free     (out_free),
        .valid    (out_valid),
        .ready    (res.ready),
        .data_out (out_data)
    );

    // Result channel
    assign res.valid         = out_valid;
    assign res.event_res     = out_data.event_res;
    assign res.payload_byte  = out_data.payload_byte;
    assign res.payload_index = out_data.payload_index;
    assign res.frame_cmd     = out_data.frame_cmd;
    assign res.frame_dir     = out_data.frame_dir;
    assign res.frame_error   = out_data.frame_error;
    assign res.frame_length  = out_data.frame_length;

`ifndef SYNTHESIS
    // A byte in the input register moves on whenever the result stage is empty
    a_step_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid) |-> step)
        else $error("input byte stalled with empty result stage");

    // Every parser step produces a pending result
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("parser step without result");

    // Disabled parser reports nothing
    a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !enable_reg) |=> (res.event_res == EV_NONE))
        else $error("event reported while disabled");
`endif

endmodule
`default_nettype wire
